>>> rtl/mcr_pkg.sv
package mcr_pkg;

    // signed coordinate wide enough for center +/- radius
    localparam int COORD_W = 12;
    // window register width and its effective ceiling
    localparam int WIN_W = 11;
    localparam logic [WIN_W-1:0] WIN_LIMIT = 11'd1024;
    localparam logic [WIN_W-1:0] WIDTH_RESET = 11'd640;
    localparam logic [WIN_W-1:0] HEIGHT_RESET = 11'd240;
    localparam int MAX_RADIUS_DEF = 10;

    // register indexes (paddr[2])
    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    // candidate span from the sequencer to the clip unit and output stage
    typedef struct packed {
        logic   valid;
        logic   flush;
        coord_t xa;
        coord_t xb;
        coord_t yy;
    } gen_t;

endpackage

>>> rtl/mcr_clip.sv
module mcr_clip
    import mcr_pkg::*;
(
    input  logic [WIN_W-1:0] win_width,
    input  logic [WIN_W-1:0] win_height,
    input  gen_t             gen,
    output logic             keep,
    output logic [9:0]       x_left,
    output logic [9:0]       x_right,
    output logic [9:0]       row
);

    logic [WIN_W-1:0]      w_eff;
    logic [WIN_W-1:0]      h_eff;
    logic signed [COORD_W:0] w_s;
    logic signed [COORD_W:0] h_s;
    logic signed [COORD_W:0] lo;
    logic signed [COORD_W:0] hi;
    logic signed [COORD_W:0] y_s;
    logic signed [COORD_W:0] lo_c;
    logic signed [COORD_W:0] hi_c;

    // window registers above 1024 act as 1024
    assign w_eff = (win_width > WIN_LIMIT) ? WIN_LIMIT : win_width;
    assign h_eff = (win_height > WIN_LIMIT) ? WIN_LIMIT : win_height;
    assign w_s = $signed({2'b00, w_eff});
    assign h_s = $signed({2'b00, h_eff});

    // order the span ends
    always_comb begin
        if (gen.xa < gen.xb) begin
            lo = {gen.xa[COORD_W-1], gen.xa};
            hi = {gen.xb[COORD_W-1], gen.xb};
        end else begin
            lo = {gen.xb[COORD_W-1], gen.xb};
            hi = {gen.xa[COORD_W-1], gen.xa};
        end
    end

    assign y_s = {gen.yy[COORD_W-1], gen.yy};

    // drop off-window rows and spans, clamp the rest
    assign keep = (y_s >= 0) && (y_s < h_s) && (hi >= 0) && (lo < w_s);
    assign lo_c = (lo < 0) ? '0 : lo;
    assign hi_c = (hi > w_s - 13'sd1) ? w_s - 13'sd1 : hi;

    assign x_left  = lo_c[9:0];
    assign x_right = hi_c[9:0];
    assign row     = y_s[9:0];

endmodule

>>> rtl/mcr_seq.sv
module mcr_seq
    import mcr_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic       kind,
    input  logic [9:0] center_x,
    input  logic [9:0] center_y,
    input  logic [3:0] radius,
    input  logic       out_free,
    output logic       idle,
    output gen_t       gen
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_AXIS = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [3:0] R_MAX = 4'(MAX_RADIUS);

    logic [2:0]       state_reg, state_next;
    logic [2:0]       phase_reg, phase_next;
    logic             filled_reg;
    coord_t           cx_reg, cy_reg;
    logic [3:0]       x_reg, x_next;
    logic [3:0]       y_reg, y_next;
    logic signed [7:0] f_reg, f_next;
    logic signed [7:0] ddx_reg, ddx_next;
    logic signed [7:0] ddy_reg, ddy_next;
    logic [3:0]       r_sat;
    logic [2:0]       phase_last;
    logic signed [5:0] px, nx, py, ny;
    logic signed [5:0] oa, ob, oy;
    logic signed [7:0] ddy_up, f_y;

    assign r_sat = (radius > R_MAX) ? R_MAX : radius;
    assign idle  = (state_reg == ST_IDLE);

    // request registers
    always_ff @(posedge aclk) begin
        if (start) begin
            filled_reg <= kind;
            cx_reg     <= coord_t'({2'b00, center_x});
            cy_reg     <= coord_t'({2'b00, center_y});
        end
    end

    // offsets for the current phase
    assign px = $signed({2'b00, x_reg});
    assign nx = -px;
    assign py = $signed({2'b00, y_reg});
    assign ny = -py;

    always_comb begin
        oa = '0;
        ob = '0;
        oy = '0;
        if (state_reg == ST_AXIS) begin
            case (phase_reg)
                3'd0: begin oa = '0; ob = '0; oy = py; end
                3'd1: begin oa = '0; ob = '0; oy = ny; end
                3'd2: begin oa = py; ob = filled_reg ? ny : py; oy = '0; end
                3'd3: begin oa = ny; ob = ny; oy = '0; end
                default: begin oa = '0; ob = '0; oy = '0; end
            endcase
        end else if (filled_reg) begin
            case (phase_reg)
                3'd0: begin oa = px; ob = nx; oy = py; end
                3'd1: begin oa = px; ob = nx; oy = ny; end
                3'd2: begin oa = py; ob = ny; oy = px; end
                3'd3: begin oa = py; ob = ny; oy = nx; end
                default: begin oa = '0; ob = '0; oy = '0; end
            endcase
        end else begin
            case (phase_reg)
                3'd0: begin oa = px; oy = py; end
                3'd1: begin oa = nx; oy = py; end
                3'd2: begin oa = px; oy = ny; end
                3'd3: begin oa = nx; oy = ny; end
                3'd4: begin oa = py; oy = px; end
                3'd5: begin oa = ny; oy = px; end
                3'd6: begin oa = py; oy = nx; end
                3'd7: begin oa = ny; oy = nx; end
                default: begin oa = '0; oy = '0; end
            endcase
            ob = oa;
        end
    end

    // center plus offset adders, one per coordinate
    always_comb begin
        gen.valid = ((state_reg == ST_AXIS) || (state_reg == ST_EMIT)) && out_free;
        gen.flush = (state_reg == ST_DONE) && out_free;
        gen.xa = cx_reg + coord_t'(oa);
        gen.xb = cx_reg + coord_t'(ob);
        gen.yy = cy_reg + coord_t'(oy);
    end

    // midpoint decision update
    assign ddy_up = ddy_reg + 8'sd2;
    assign f_y    = (f_reg >= 0) ? f_reg + ddy_up : f_reg;

    always_comb begin
        phase_last = 3'd0;
        if (state_reg == ST_AXIS) begin
            phase_last = filled_reg ? 3'd2 : 3'd3;
        end else begin
            phase_last = filled_reg ? 3'd3 : 3'd7;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        f_next     = f_reg;
        ddx_next   = ddx_reg;
        ddy_next   = ddy_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_AXIS;
                    phase_next = '0;
                    x_next     = '0;
                    y_next     = r_sat;
                    f_next     = 8'sd1 - $signed({4'b0000, r_sat});
                    ddx_next   = 8'sd1;
                    ddy_next   = -$signed({3'b000, r_sat, 1'b0});
                end
            end
            ST_AXIS, ST_EMIT: begin
                if (out_free) begin
                    if (phase_reg == phase_last) begin
                        state_next = ST_STEP;
                        phase_next = '0;
                    end else begin
                        phase_next = phase_reg + 3'd1;
                    end
                end
            end
            ST_STEP: begin
                if (x_reg < y_reg) begin
                    if (f_reg >= 0) begin
                        y_next   = y_reg - 4'd1;
                        ddy_next = ddy_up;
                    end
                    x_next     = x_reg + 4'd1;
                    ddx_next   = ddx_reg + 8'sd2;
                    f_next     = f_y + ddx_reg + 8'sd2;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        f_reg   <= f_next;
        ddx_reg <= ddx_next;
        ddy_reg <= ddy_next;
    end

endmodule

>>> rtl/midpoint_circle_rasterizer_top.sv
// Channel   Dir  Ports                 Contents
// s_*       in   tvalid/tready/tdata   circle request beat, tuser = kind
// m_*       out  tvalid/tready/tdata   span or pixel beat, tlast = final of request
// apb       in   psel/penable/...      window_width (0x0), window_height (0x4)
//
// One request at a time: s_tready is high only while the sequencer is idle.
// A request is accepted, then the sequencer emits one candidate per cycle unless
// m_tready stalls (4 axis for an outline, 3 for a filled one, then 8 or 4 per
// midpoint step), with a step state between groups, the loop exit test and a flush.
// Results are held back one deep so the final kept beat can carry tlast.
// m_tready low stalls the sequencer; reset is synchronous, active low.
module midpoint_circle_rasterizer_top
    import mcr_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // center_x[9:0], center_y[19:10], radius[23:20], color[31:24]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // x_left[9:0], x_right[19:10], row[29:20], pixel_color[37:30]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [WIN_W-1:0] width_reg;
    logic [WIN_W-1:0] height_reg;
    logic [7:0]       color_reg;
    logic             start;
    logic             idle;
    logic             out_free;
    gen_t             gen;
    logic             keep;
    logic [9:0]       x_left, x_right, row;
    logic             hold_valid_reg;
    logic [29:0]      hold_reg;
    logic             m_tvalid_reg;
    logic [39:0]      m_tdata_reg;
    logic             m_tlast_reg;

    // configuration port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_WIDTH) begin
                width_reg <= pwdata[WIN_W-1:0];
            end else begin
                height_reg <= pwdata[WIN_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_HEIGHT) begin
            prdata = {{(32-WIN_W){1'b0}}, height_reg};
        end else begin
            prdata = {{(32-WIN_W){1'b0}}, width_reg};
        end
    end

    // request accept
    assign s_tready = idle;
    assign start    = s_tvalid && idle;
    always_ff @(posedge aclk) begin
        if (start) begin
            color_reg <= s_tdata[31:24];
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    mcr_seq #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .kind     (s_tuser),
        .center_x (s_tdata[9:0]),
        .center_y (s_tdata[19:10]),
        .radius   (s_tdata[23:20]),
        .out_free (out_free),
        .idle     (idle),
        .gen      (gen)
    );

    mcr_clip u_clip (
        .win_width  (width_reg),
        .win_height (height_reg),
        .gen        (gen),
        .keep       (keep),
        .x_left     (x_left),
        .x_right    (x_right),
        .row        (row)
    );

    // one-deep holdback and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (gen.valid && keep) begin
                hold_valid_reg <= 1'b1;
                m_tvalid_reg   <= hold_valid_reg || (m_tvalid_reg && !m_tready);
            end else if (gen.flush) begin
                hold_valid_reg <= 1'b0;
                m_tvalid_reg   <= hold_valid_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (gen.valid && keep) begin
            hold_reg <= {row, x_right, x_left};
            if (hold_valid_reg) begin
                m_tdata_reg <= {2'b00, color_reg, hold_reg};
                m_tlast_reg <= 1'b0;
            end
        end else if (gen.flush && hold_valid_reg) begin
            m_tdata_reg <= {2'b00, color_reg, hold_reg};
            m_tlast_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
